>>> hdl/mst_pkg.sv
// Shared types, codes and keyword table for the markup source tokenizer.
// No dependencies.
package mst_pkg;

  localparam int CW = 32;
  localparam int NKW = 22;
  localparam int KW_BYTES = 13;
  localparam logic [CW-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_UNQ, M_STR, M_ESC, M_HSLASH, M_HDASH,
    M_LINECOM, M_BLOCK, M_BSTAR
  } mode_t;

  localparam logic [5:0] K_END = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_STRING = 6'd2;
  localparam logic [5:0] K_UNQ = 6'd3;
  localparam logic [5:0] K_PUNCT0 = 6'd4;
  localparam logic [5:0] K_UNKNOWN = 6'd18;
  localparam logic [5:0] K_KW0 = 6'd19;

  typedef struct packed {
    logic [5:0]    kind;
    logic [CW-1:0] line;
    logic [CW-1:0] column;
    logic [CW-1:0] offset;
    logic [CW-1:0] vlen;
    logic          last;
  } res_t;

  typedef logic [8*KW_BYTES-1:0] kw_word_t;

  localparam kw_word_t KW_STR [NKW] = '{
    "text", "style", "script", "Template", "Custom", "Origin", "Import",
    "Namespace", "Configuration", "Info", "Export", "use", "except",
    "inherit", "delete", "insert", "after", "before", "replace", "at",
    "from", "as"
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd4, 4'd5, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd9, 4'd13, 4'd4, 4'd6,
    4'd3, 4'd6, 4'd7, 4'd6, 4'd6, 4'd5, 4'd6, 4'd7, 4'd2, 4'd4, 4'd2
  };

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Clear every keyword that is too short for pos or whose character at pos differs from c.
  function automatic logic [NKW-1:0] kw_step(input logic [NKW-1:0] hits,
                                             input logic [CW-1:0] pos,
                                             input logic [7:0] c);
    logic [NKW-1:0] h;
    logic [3:0]     p;
    logic [7:0]     b;
    h = hits;
    p = pos[3:0];
    for (int k = 0; k < NKW; k++) begin
      b = KW_STR[k][8*(KW_LEN[k] - 4'd1 - p) +: 8];
      if (pos >= CW'(KW_LEN[k]) || b != c) h[k] = 1'b0;
    end
    return h;
  endfunction

  // First surviving keyword of matching length, else identifier.
  function automatic logic [5:0] kw_kind(input logic [NKW-1:0] hits,
                                         input logic [CW-1:0] len);
    logic [5:0] kd;
    logic       found;
    kd = K_IDENT;
    found = 1'b0;
    for (int k = 0; k < NKW; k++) begin
      if (!found && hits[k] && len == CW'(KW_LEN[k])) begin
        kd = K_KW0 + 6'(k);
        found = 1'b1;
      end
    end
    return kd;
  endfunction

  function automatic logic [4:0] punct_idx(input logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      "{": r = 5'd0;
      "}": r = 5'd1;
      "[": r = 5'd2;
      "]": r = 5'd3;
      "(": r = 5'd4;
      ")": r = 5'd5;
      ";": r = 5'd6;
      ":": r = 5'd7;
      "=": r = 5'd8;
      ",": r = 5'd9;
      ".": r = 5'd10;
      "@": r = 5'd11;
      "#": r = 5'd12;
      "&": r = 5'd13;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/markup_source_tokenizer.sv
// Markup source tokenizer: one source byte per request in, token requests out.
// Depends on mst_pkg.
//
// The block takes one input request per cycle and turns it, in a single pass of
// logic, into zero to three token requests written to a four-entry result
// queue. Whitespace and //, -- and /* */ comments are skipped; identifiers are
// matched against 22 keywords as their bytes arrive; strings, unquoted
// literals, punctuation and unknown bytes become tokens that carry their start
// line, column, byte offset and value length. in_ready is high while the queue
// holds at most one request, so a stream whose bytes give one token or fewer
// runs at one byte per cycle while out_ready stays high; a byte that gives two
// or three tokens (an end request flushing a pending token, for instance) holds
// off further bytes while the queue drains. Outputs come from the registered
// queue. The end request always closes with an end token and returns the
// scanner to its reset state.
module markup_source_tokenizer import mst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_ch,
  input  logic          in_has_char,
  input  logic          in_end_of_source,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    out_kind,
  output logic [CW-1:0] out_line,
  output logic [CW-1:0] out_column,
  output logic [CW-1:0] out_offset,
  output logic [CW-1:0] out_value_length,
  output logic          out_last_of_run
);

  // Scanner state
  mode_t          mode_r, mode_nxt;
  logic [CW-1:0]  line_r, line_nxt, col_r, col_nxt, idx_r, idx_nxt;
  logic [CW-1:0]  sl_r, sl_nxt, sc_r, sc_nxt, si_r, si_nxt, vc_r, vc_nxt;
  logic [NKW-1:0] kh_r, kh_nxt;
  logic           qs_r, qs_nxt;

  // Result queue
  res_t       q_r [4];
  logic [1:0] rd_r;
  logic [2:0] cnt_r;

  res_t       res [3];
  logic [1:0] nres;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready  = (cnt_r <= 3'd1);
  assign out_valid = (cnt_r != 3'd0);

  always_comb begin
    logic       go_idle, nl;
    logic [7:0] c;
    logic [4:0] pi;
    mode_nxt = mode_r;
    line_nxt = line_r; col_nxt = col_r; idx_nxt = idx_r;
    sl_nxt = sl_r; sc_nxt = sc_r; si_nxt = si_r; vc_nxt = vc_r;
    kh_nxt = kh_r; qs_nxt = qs_r;
    nres = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    go_idle = 1'b0;
    nl = 1'b0;
    c = in_ch;
    pi = punct_idx(c);

    if (in_has_char) begin
      // Finish or extend whatever is pending
      unique case (mode_r)
        M_IDENT: begin
          if (is_word(c)) begin
            kh_nxt = kw_step(kh_r, vc_r, c);
            vc_nxt = sat_inc(vc_r);
          end else begin
            res[nres] = '{kw_kind(kh_r, vc_r), sl_r, sc_r, si_r, vc_r, 1'b0};
            nres = nres + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_UNQ: begin
          if (is_word(c) || c == "-") vc_nxt = sat_inc(vc_r);
          else begin
            res[nres] = '{K_UNQ, sl_r, sc_r, si_r, vc_r, 1'b0};
            nres = nres + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_STR: begin
          if (c == (qs_r ? 8'h27 : 8'h22)) begin
            res[nres] = '{K_STRING, sl_r, sc_r, si_r, vc_r, 1'b0};
            nres = nres + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == 8'h5C) mode_nxt = M_ESC;
          else vc_nxt = sat_inc(vc_r);
        end
        M_ESC: begin
          vc_nxt = sat_inc(vc_r);
          mode_nxt = M_STR;
        end
        M_HSLASH: begin
          if (c == "/") mode_nxt = M_LINECOM;
          else if (c == "*") mode_nxt = M_BLOCK;
          else begin
            res[nres] = '{K_UNKNOWN, sl_r, sc_r, si_r, CW'(1), 1'b0};
            nres = nres + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_HDASH: begin
          if (c == "-") mode_nxt = M_LINECOM;
          else if (is_word(c)) begin
            mode_nxt = M_UNQ;
            vc_nxt = CW'(2);
          end else begin
            res[nres] = '{K_UNQ, sl_r, sc_r, si_r, CW'(1), 1'b0};
            nres = nres + 2'd1;
            go_idle = 1'b1;
          end
        end
        M_LINECOM: go_idle = (c == 8'h0A);
        M_BLOCK: begin
          if (c == "*") mode_nxt = M_BSTAR;
          nl = (c == 8'h0A);
        end
        M_BSTAR: begin
          if (c == "/") mode_nxt = M_IDLE;
          else if (c != "*") mode_nxt = M_BLOCK;
          nl = (c == 8'h0A);
        end
        default: go_idle = 1'b1;
      endcase

      // Byte seen with nothing pending
      if (go_idle) begin
        mode_nxt = M_IDLE;
        if (is_space(c)) nl = (c == 8'h0A);
        else begin
          sl_nxt = line_r; sc_nxt = col_r; si_nxt = idx_r;
          if (c == "/") mode_nxt = M_HSLASH;
          else if (c == "-") mode_nxt = M_HDASH;
          else if (is_alpha(c) || c == "_") begin
            mode_nxt = M_IDENT;
            kh_nxt = kw_step('1, '0, c);
            vc_nxt = CW'(1);
          end else if (is_digit(c)) begin
            mode_nxt = M_UNQ;
            vc_nxt = CW'(1);
          end else if (c == 8'h22 || c == 8'h27) begin
            mode_nxt = M_STR;
            qs_nxt = (c == 8'h27);
            vc_nxt = '0;
          end else if (pi != 5'd31) begin
            res[nres] = '{K_PUNCT0 + 6'(pi), line_r, col_r, idx_r, CW'(1), 1'b0};
            nres = nres + 2'd1;
          end else begin
            res[nres] = '{K_UNKNOWN, line_r, col_r, idx_r, CW'(1), 1'b0};
            nres = nres + 2'd1;
          end
        end
      end

      idx_nxt = sat_inc(idx_r);
      if (nl) begin
        line_nxt = sat_inc(line_r);
        col_nxt = CW'(1);
      end else col_nxt = sat_inc(col_r);
    end

    if (in_end_of_source) begin
      // Flush the pending token, close with the end token, return to reset
      unique case (mode_nxt)
        M_IDENT: begin
          res[nres] = '{kw_kind(kh_nxt, vc_nxt), sl_nxt, sc_nxt, si_nxt, vc_nxt, 1'b0};
          nres = nres + 2'd1;
        end
        M_UNQ: begin
          res[nres] = '{K_UNQ, sl_nxt, sc_nxt, si_nxt, vc_nxt, 1'b0};
          nres = nres + 2'd1;
        end
        M_STR, M_ESC: begin
          res[nres] = '{K_STRING, sl_nxt, sc_nxt, si_nxt, vc_nxt, 1'b0};
          nres = nres + 2'd1;
        end
        M_HSLASH: begin
          res[nres] = '{K_UNKNOWN, sl_nxt, sc_nxt, si_nxt, CW'(1), 1'b0};
          nres = nres + 2'd1;
        end
        M_HDASH: begin
          res[nres] = '{K_UNQ, sl_nxt, sc_nxt, si_nxt, CW'(1), 1'b0};
          nres = nres + 2'd1;
        end
        default: ;
      endcase
      res[nres] = '{K_END, line_nxt, col_nxt, idx_nxt, '0, 1'b0};
      nres = nres + 2'd1;
      mode_nxt = M_IDLE;
      line_nxt = CW'(1); col_nxt = CW'(1); idx_nxt = '0;
      sl_nxt = '0; sc_nxt = '0; si_nxt = '0; vc_nxt = '0;
      kh_nxt = '1; qs_nxt = 1'b0;
    end

    if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= CW'(1); col_r <= CW'(1); idx_r <= '0;
      sl_r <= '0; sc_r <= '0; si_r <= '0; vc_r <= '0;
      kh_r <= '1; qs_r <= 1'b0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        line_r <= line_nxt; col_r <= col_nxt; idx_r <= idx_nxt;
        sl_r <= sl_nxt; sc_r <= sc_nxt; si_r <= si_nxt; vc_r <= vc_nxt;
        kh_r <= kh_nxt; qs_r <= qs_nxt;
      end
      // advance read side, add new results behind the current tail
      if (out_acc) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r - {2'b0, out_acc} + (in_acc ? {1'b0, nres} : 3'd0);
    end
  end

  // Queue storage: payload only, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) q_r[2'(rd_r + cnt_r[1:0] + 2'(i))] <= res[i];
      end
    end
  end

  assign out_kind         = q_r[rd_r].kind;
  assign out_line         = q_r[rd_r].line;
  assign out_column       = q_r[rd_r].column;
  assign out_offset       = q_r[rd_r].offset;
  assign out_value_length = q_r[rd_r].vlen;
  assign out_last_of_run  = q_r[rd_r].last;

  // Queue never holds more than its four entries
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");
  // An accepted request always leaves room for its results
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r + {1'b0, nres} <= 3'd4))
    else $error("no room for results");
  // An end request leaves the scanner idle at line one
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_source) |=> (mode_r == M_IDLE && line_r == CW'(1)))
    else $error("end request did not reset scanner");
  // An end request always produces at least one result
  a_end_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_source) |-> nres != 2'd0)
    else $error("end request without end token");

endmodule

>>> dv/tb_markup_source_tokenizer.sv
// Self-checking testbench for markup_source_tokenizer: random and directed byte
// streams, token predictor, scoreboard. Depends on mst_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_markup_source_tokenizer import mst_pkg::*; ();

  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       eos;
    bit         drain_first;   // hold this request until all tokens are out
  } src_req_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    in_ch = '0;
  logic          in_has_char = 1'b0;
  logic          in_end_of_source = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [5:0]    out_kind;
  logic [CW-1:0] out_line, out_column, out_offset, out_value_length;
  logic          out_last_of_run;

  markup_source_tokenizer uut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token predictor: own copy of the scanner state, updated per accepted request
  // ---------------------------------------------------------------------------
  string kw_names[NKW] = '{"text", "style", "script", "Template", "Custom", "Origin",
    "Import", "Namespace", "Configuration", "Info", "Export", "use", "except",
    "inherit", "delete", "insert", "after", "before", "replace", "at", "from", "as"};
  string punct_chars = "{}[]();:=,.@#&";

  mode_t          scan;
  logic [CW-1:0]  cur_line, cur_col, cur_idx;
  logic [CW-1:0]  tok_line, tok_col, tok_idx, val_cnt;
  logic [NKW-1:0] kw_alive;
  bit             single_quote;

  res_t tok_batch[$];     // tokens of the request being predicted
  res_t expected_toks[$]; // tokens still owed by the block
  int   err_cnt = 0;

  function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return letter(c) || digit(c) || c == "_";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_scanner();
    scan = M_IDLE;
    cur_line = 1;
    cur_col = 1;
    cur_idx = 0;
    tok_line = 0;
    tok_col = 0;
    tok_idx = 0;
    val_cnt = 0;
    kw_alive = '1;
    single_quote = 0;
  endfunction

  function automatic void add_tok(logic [5:0] kind, logic [CW-1:0] l, logic [CW-1:0] c,
                                  logic [CW-1:0] o, logic [CW-1:0] len);
    res_t t;
    t.kind = kind; t.line = l; t.column = c; t.offset = o; t.vlen = len; t.last = 1'b0;
    if (tok_batch.size() < 3) tok_batch.insert(tok_batch.size(), t);
  endfunction

  function automatic void add_open_tok(logic [5:0] kind, logic [CW-1:0] len);
    add_tok(kind, tok_line, tok_col, tok_idx, len);
  endfunction

  // Drop every keyword that does not have c at position pos.
  function automatic void narrow_keywords(logic [CW-1:0] pos, logic [7:0] c);
    for (int k = 0; k < NKW; k++)
      if (pos >= kw_names[k].len() || kw_names[k][int'(pos)] != c) kw_alive[k] = 1'b0;
  endfunction

  function automatic void close_word();
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = NKW - 1; k >= 0; k--)
      if (kw_alive[k] && val_cnt == kw_names[k].len()) kind = K_KW0 + 6'(k);
    add_open_tok(kind, val_cnt);
  endfunction

  // Byte with nothing open; returns 1 on a newline.
  function automatic bit fresh_byte(logic [7:0] c);
    scan = M_IDLE;
    if (blank(c)) return c == 8'h0a;
    tok_line = cur_line;
    tok_col = cur_col;
    tok_idx = cur_idx;
    if (c == "/") scan = M_HSLASH;
    else if (c == "-") scan = M_HDASH;
    else if (letter(c) || c == "_") begin
      scan = M_IDENT;
      kw_alive = '1;
      narrow_keywords(0, c);
      val_cnt = 1;
    end else if (digit(c)) begin
      scan = M_UNQ;
      val_cnt = 1;
    end else if (c == "\"" || c == "'") begin
      scan = M_STR;
      single_quote = (c == "'");
      val_cnt = 0;
    end else begin
      for (int i = 0; i < punct_chars.len(); i++)
        if (punct_chars[i] == c) begin
          add_open_tok(K_PUNCT0 + 6'(i), 1);
          return 0;
        end
      add_open_tok(K_UNKNOWN, 1);
    end
    return 0;
  endfunction

  function automatic bit scan_byte(logic [7:0] c);
    case (scan)
      M_IDENT: begin
        if (word_char(c)) begin
          narrow_keywords(val_cnt, c);
          val_cnt = bump(val_cnt);
          return 0;
        end
        close_word();
        return fresh_byte(c);
      end
      M_UNQ: begin
        if (word_char(c) || c == "-") begin
          val_cnt = bump(val_cnt);
          return 0;
        end
        add_open_tok(K_UNQ, val_cnt);
        return fresh_byte(c);
      end
      M_STR: begin
        if (c == (single_quote ? 8'h27 : 8'h22)) begin
          add_open_tok(K_STRING, val_cnt);
          scan = M_IDLE;
        end else if (c == 8'h5c) scan = M_ESC;
        else val_cnt = bump(val_cnt);
        return 0;
      end
      M_ESC: begin
        val_cnt = bump(val_cnt);
        scan = M_STR;
        return 0;
      end
      M_HSLASH: begin
        if (c == "/") begin scan = M_LINECOM; return 0; end
        if (c == "*") begin scan = M_BLOCK; return 0; end
        add_open_tok(K_UNKNOWN, 1);
        return fresh_byte(c);
      end
      M_HDASH: begin
        if (c == "-") begin scan = M_LINECOM; return 0; end
        if (word_char(c)) begin scan = M_UNQ; val_cnt = 2; return 0; end
        add_open_tok(K_UNQ, 1);
        return fresh_byte(c);
      end
      M_LINECOM: return (c == 8'h0a) ? fresh_byte(c) : 0;
      M_BLOCK: begin
        if (c == "*") scan = M_BSTAR;
        return c == 8'h0a;
      end
      M_BSTAR: begin
        if (c == "/") scan = M_IDLE;
        else if (c != "*") scan = M_BLOCK;
        return c == 8'h0a;
      end
      default: return fresh_byte(c);
    endcase
  endfunction

  // Predict the tokens of one accepted request and queue them.
  function automatic void predict_tokens(logic [7:0] c, logic has, logic fin);
    bit nl;
    tok_batch.delete();
    if (has) begin
      nl = scan_byte(c);
      cur_idx = bump(cur_idx);
      if (nl) begin
        cur_line = bump(cur_line);
        cur_col = 1;
      end else cur_col = bump(cur_col);
    end
    if (fin) begin
      case (scan)
        M_IDENT: close_word();
        M_UNQ: add_open_tok(K_UNQ, val_cnt);
        M_STR, M_ESC: add_open_tok(K_STRING, val_cnt);
        M_HSLASH: add_open_tok(K_UNKNOWN, 1);
        M_HDASH: add_open_tok(K_UNQ, 1);
        default: ;
      endcase
      add_tok(K_END, cur_line, cur_col, cur_idx, 0);
      clear_scanner();
    end
    if (tok_batch.size() > 0) tok_batch[$].last = 1'b1;
    foreach (tok_batch[i]) expected_toks.insert(expected_toks.size(), tok_batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  src_req_t pending_reqs[$];

  function automatic void add_req(logic [7:0] c, logic has = 1, logic fin = 0,
                                  bit drain = 0);
    src_req_t r;
    r.ch = c; r.has_char = has; r.eos = fin; r.drain_first = drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_req(s[i]);
  endfunction

  function automatic void add_word();
    int n;
    n = $urandom_range(1, 6);
    add_req($urandom_range(0, 1) ? 8'h5f : 8'("a" + $urandom_range(0, 25)));
    for (int i = 1; i < n; i++)
      case ($urandom_range(0, 3))
        0: add_req(8'("0" + $urandom_range(0, 9)));
        1: add_req(8'("A" + $urandom_range(0, 25)));
        default: add_req(8'("a" + $urandom_range(0, 25)));
      endcase
  endfunction

  function automatic void add_quoted();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? 8'h27 : 8'h22;
    add_req(q);
    repeat ($urandom_range(0, 5))
      case ($urandom_range(0, 5))
        0: begin add_req(8'h5c); add_req(8'($urandom_range(0, 255))); end
        1: add_req(8'h0a);
        default: add_req(8'("a" + $urandom_range(0, 25)));
      endcase
    if ($urandom_range(0, 7) != 0) add_req(q);
  endfunction

  // One random piece of source: mostly well formed tokens, some noise.
  function automatic void add_piece();
    case ($urandom_range(0, 13))
      0, 1: add_text(kw_names[$urandom_range(0, NKW - 1)]);
      2, 3: add_word();
      4:    add_quoted();
      5:    begin
              if ($urandom_range(0, 1)) add_req("-");
              add_req(8'("0" + $urandom_range(0, 9)));
              repeat ($urandom_range(0, 3)) add_req($urandom_range(0, 1) ? "-" : "7");
            end
      6, 7: add_req(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      8:    begin add_text($urandom_range(0, 1) ? "//" : "--"); add_word(); add_req(8'h0a); end
      9:    begin add_text("/*"); add_word(); add_text($urandom_range(0, 1) ? "**/" : "*\n*/"); end
      10:   add_req($urandom_range(0, 1) ? "/" : "-");
      11:   add_req(8'($urandom_range(0, 255)));
      12:   add_req(0, 0, 0);
      default: add_req($urandom_range(0, 1) ? 8'h0a : 8'h20);
    endcase
    if ($urandom_range(0, 2) == 0) add_req($urandom_range(0, 1) ? 8'h20 : 8'h09);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: requests change on the falling edge
  // ---------------------------------------------------------------------------
  int  cyc = 0;
  bit  in_took = 0;
  bit  all_sent = 0;

  // quiet stretch: nobody idles; hold-off stretch: receiver blocks everything
  function automatic bit quiet_window();
    return cyc >= 260 && cyc < 380;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
        all_sent <= 1'b1;
      end else if (pending_reqs[0].drain_first && expected_toks.size() != 0) begin
        in_valid <= 1'b0;   // wait for the block to drain
      end else if (!quiet_window() && $urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_ch <= pending_reqs[0].ch;
        in_has_char <= pending_reqs[0].has_char;
        in_end_of_source <= pending_reqs[0].eos;
        void'(pending_reqs.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) out_ready <= 1'b0;
    else if (cyc >= 120 && cyc < 200) out_ready <= 1'b0;  // long hold-off
    else out_ready <= quiet_window() || $urandom_range(0, 99) >= 25;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_tokens(in_ch, in_has_char, in_end_of_source);
    if (rst_n && out_valid && out_ready) begin
      if (expected_toks.size() == 0) begin
        $error("token with none expected: kind %0d offset %0d", out_kind, out_offset);
        err_cnt++;
      end else begin
        want = expected_toks.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind); err_cnt++;
        end
        if (out_line !== want.line) begin
          $error("line: expected %0d, got %0d", want.line, out_line); err_cnt++;
        end
        if (out_column !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, out_column); err_cnt++;
        end
        if (out_offset !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, out_offset); err_cnt++;
        end
        if (out_value_length !== want.vlen) begin
          $error("value_length: expected %0d, got %0d", want.vlen, out_value_length);
          err_cnt++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  always @(posedge clk) begin
    if (cyc > 200000) begin
      $display("tb_markup_source_tokenizer: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed sources, then random ones
  // ---------------------------------------------------------------------------
  initial begin
    clear_scanner();
    // keywords, identifier, punctuation, string with escape and newline
    add_text("at Configuration{x1};'a\\'\nb\"'");
    add_req(0, 0, 0);                 // empty request: nothing happens
    add_text("//c\n--d\n/*\n**/ - -1 /x ");
    add_req(8'h00); add_req(8'hff); add_req(8'h80);
    add_text("[]()=:,.@#&");
    add_req("/", 1, 1);               // end with a held slash
    add_req("-", 1, 1);               // end with a held dash
    add_text("\"open");
    add_req(0, 0, 1);                 // unterminated string, end-only request
    add_text("/* open");
    add_req(" ", 1, 1, 1);            // open comment dropped; drain first
    add_text("Namespace text");
    add_req(0, 0, 1);

    while (pending_reqs.size() < 230) begin
      add_piece();
      if ($urandom_range(0, 19) == 0)
        add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1);
      if ($urandom_range(0, 59) == 0) add_req(" ", 1, 0, 1);
    end
    add_req(0, 0, 1);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    wait (all_sent && expected_toks.size() == 0);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_toks.size() == 0)
      $display("tb_markup_source_tokenizer: done, clean");
    else
      $display("tb_markup_source_tokenizer: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/mst_pkg.sv
hdl/markup_source_tokenizer.sv
dv/tb_markup_source_tokenizer.sv
